@@ rtl/wia_pkg.sv @@
// Package: command codes and defaults for the wide integer ALU.
package wia_pkg;

    localparam int unsigned WIDTH_DEFAULT = 128;

    typedef enum logic [3:0] {
        CMD_ADD  = 4'd0,
        CMD_SUB  = 4'd1,
        CMD_NEG  = 4'd2,
        CMD_MUL  = 4'd3,
        CMD_DIV  = 4'd4,
        CMD_AND  = 4'd5,
        CMD_OR   = 4'd6,
        CMD_XOR  = 4'd7,
        CMD_NOT  = 4'd8,
        CMD_SHLK = 4'd9,
        CMD_SAR  = 4'd10,
        CMD_SHL  = 4'd11,
        CMD_SHR  = 4'd12
    } cmd_t;

endpackage

@@ rtl/wide_integer_alu.sv @@
// Top level: pipelined wide integer ALU built as a chain of cells.
//
// Use: drive cmd, a_high/a_low, b_high/b_low and shift_amount and raise
// start; the beat is taken on any edge with start high, and busy is always
// low, so a new beat may enter every cycle.
// Throughput: one beat per cycle for every command.
// Pipeline: input register, a chain of WIDTH cells (one per operand bit for
// multiply and divide) and output register, the same path for every command.
// Add, logic and shifts are worked out on entry and ride the chain so
// results stay in order.
// Each cell performs one shift-add multiply bit and one restoring
// divide step; the divide runs on magnitudes and the quotient sign is
// fixed in the output stage.
// Results: done pulses for one cycle with result, remainder and flags.
// The receiver cannot stall; nothing is held back.
// Reset: rst_n clears all valid bits; beats in flight are dropped.
// Width below 128: upper operand bits are ignored, upper result bits zero.
module wide_integer_alu #(
    parameter int unsigned WIDTH = wia_pkg::WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  cmd,
    input  logic [63:0] a_high,
    input  logic [63:0] a_low,
    input  logic [63:0] b_high,
    input  logic [63:0] b_low,
    input  logic [7:0]  shift_amount,
    output logic        done,
    output logic [63:0] result_high,
    output logic [63:0] result_low,
    output logic [63:0] remainder_high,
    output logic [63:0] remainder_low,
    output logic        is_zero,
    output logic        is_negative
);
    localparam int unsigned SW = $clog2(WIDTH) + 1;

    // input register
    logic             v0_reg;
    logic [3:0]       cmd0_reg;
    logic [WIDTH-1:0] a0_reg, b0_reg;
    logic [7:0]       s0_reg;
    logic [127:0]     a_full, b_full;

    assign busy   = 1'b0;
    assign a_full = {a_high, a_low};
    assign b_full = {b_high, b_low};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        cmd0_reg <= cmd;
        a0_reg   <= a_full[WIDTH-1:0];
        b0_reg   <= b_full[WIDTH-1:0];
        s0_reg   <= shift_amount;
    end

    // stage-0 combinational: simple ops and chain setup
    logic [WIDTH-1:0] simple_res, ca, cb, ca_sh, sar_r;
    logic             sign_a, cflip, big;
    logic [SW-1:0]    sa;

    assign sign_a = a0_reg[WIDTH-1];
    assign big    = (s0_reg >= 8'(WIDTH));
    assign sa     = big ? SW'(WIDTH - 1) : SW'(s0_reg);
    assign sar_r  = $unsigned($signed(a0_reg) >>> sa);

    always_comb
    begin
        simple_res = '0;
        ca         = a0_reg;
        cb         = b0_reg;
        cflip      = 1'b0;
        ca_sh      = '0;
        case (cmd0_reg)
            wia_pkg::CMD_ADD: simple_res = a0_reg + b0_reg;
            wia_pkg::CMD_SUB: simple_res = a0_reg - b0_reg;
            wia_pkg::CMD_NEG: simple_res = '0 - a0_reg;
            wia_pkg::CMD_AND: simple_res = a0_reg & b0_reg;
            wia_pkg::CMD_OR:  simple_res = a0_reg | b0_reg;
            wia_pkg::CMD_XOR: simple_res = a0_reg ^ b0_reg;
            wia_pkg::CMD_NOT: simple_res = ~a0_reg;
            wia_pkg::CMD_SHLK:
            begin
                ca_sh = big ? '0 : (a0_reg << sa);
                simple_res = {sign_a, ca_sh[WIDTH-2:0]};
            end
            wia_pkg::CMD_SAR: simple_res = sar_r;
            wia_pkg::CMD_SHL: simple_res = big ? '0 : (a0_reg << sa);
            wia_pkg::CMD_SHR: simple_res = big ? '0 : (a0_reg >> sa);
            wia_pkg::CMD_DIV:
            begin
                ca    = sign_a ? ('0 - a0_reg) : a0_reg;
                cb    = b0_reg[WIDTH-1] ? ('0 - b0_reg) : b0_reg;
                cflip = sign_a ^ b0_reg[WIDTH-1];
            end
            default: simple_res = '0;
        endcase
    end

    // chain of cells
    logic             cv [WIDTH+1];
    logic [3:0]       cc [WIDTH+1];
    logic [WIDTH-1:0] cav [WIDTH+1], cbv [WIDTH+1], cacc [WIDTH+1];
    logic [WIDTH-1:0] crem [WIDTH+1], cres [WIDTH+1];
    logic             cfl [WIDTH+1];

    assign cv[0]   = v0_reg;
    assign cc[0]   = cmd0_reg;
    assign cav[0]  = ca;
    assign cbv[0]  = cb;
    assign cacc[0] = '0;
    assign crem[0] = '0;
    assign cfl[0]  = cflip;
    assign cres[0] = simple_res;

    for (genvar g = 0; g < WIDTH; g++)
    begin : g_cell
        wia_cell #(.WIDTH(WIDTH), .IDX(g)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cv[g]),
            .in_cmd    (cc[g]),
            .in_a      (cav[g]),
            .in_b      (cbv[g]),
            .in_acc    (cacc[g]),
            .in_rem    (crem[g]),
            .in_flip   (cfl[g]),
            .in_res    (cres[g]),
            .out_valid (cv[g+1]),
            .out_cmd   (cc[g+1]),
            .out_a     (cav[g+1]),
            .out_b     (cbv[g+1]),
            .out_acc   (cacc[g+1]),
            .out_rem   (crem[g+1]),
            .out_flip  (cfl[g+1]),
            .out_res   (cres[g+1])
        );
    end

    // output stage
    logic [WIDTH-1:0] fin_res, fin_rem;
    logic             done_reg;
    logic [127:0]     res_reg, rem_reg;

    always_comb
    begin
        fin_res = cres[WIDTH];
        fin_rem = '0;
        if (cc[WIDTH] == wia_pkg::CMD_MUL)
            fin_res = cacc[WIDTH];
        else if (cc[WIDTH] == wia_pkg::CMD_DIV)
        begin
            fin_res = cfl[WIDTH] ? ('0 - cacc[WIDTH]) : cacc[WIDTH];
            fin_rem = crem[WIDTH];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cv[WIDTH];
    end

    always_ff @(posedge clk)
    begin
        res_reg <= 128'(fin_res);
        rem_reg <= 128'(fin_rem);
    end

    assign done           = done_reg;
    assign result_high    = res_reg[127:64];
    assign result_low     = res_reg[63:0];
    assign remainder_high = rem_reg[127:64];
    assign remainder_low  = rem_reg[63:0];
    assign is_zero        = (res_reg == '0);
    assign is_negative    = res_reg[WIDTH-1];
endmodule

@@ rtl/wia_cell.sv @@
// One stage of the ALU chain: one multiply bit and one restoring divide step.
module wia_cell #(
    parameter int unsigned WIDTH = wia_pkg::WIDTH_DEFAULT,
    parameter int unsigned IDX   = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [3:0]       in_cmd,
    input  logic [WIDTH-1:0] in_a,     // multiplicand shifted / dividend magnitude
    input  logic [WIDTH-1:0] in_b,     // multiplier / divisor magnitude
    input  logic [WIDTH-1:0] in_acc,   // product / quotient
    input  logic [WIDTH-1:0] in_rem,
    input  logic             in_flip,
    input  logic [WIDTH-1:0] in_res,   // simple-op result carried along
    output logic             out_valid,
    output logic [3:0]       out_cmd,
    output logic [WIDTH-1:0] out_a,
    output logic [WIDTH-1:0] out_b,
    output logic [WIDTH-1:0] out_acc,
    output logic [WIDTH-1:0] out_rem,
    output logic             out_flip,
    output logic [WIDTH-1:0] out_res
);
    localparam int unsigned DBIT = WIDTH - 1 - IDX;

    logic             valid_reg;
    logic [3:0]       cmd_reg;
    logic [WIDTH-1:0] a_reg, b_reg, acc_reg, rem_reg, res_reg;
    logic             flip_reg;
    logic [WIDTH-1:0] a_next, acc_next, rem_next;
    logic [WIDTH:0]   r_sh, diff;

    always_comb
    begin
        a_next   = in_a;
        acc_next = in_acc;
        rem_next = in_rem;
        r_sh     = {in_rem, in_a[DBIT]};
        diff     = r_sh - {1'b0, in_b};
        if (in_cmd == wia_pkg::CMD_MUL)
        begin
            if (in_b[IDX])
                acc_next = in_acc + in_a;
            a_next = {in_a[WIDTH-2:0], 1'b0};
        end
        else if (in_cmd == wia_pkg::CMD_DIV)
        begin
            if ((in_b != '0) && !diff[WIDTH])
            begin
                rem_next       = diff[WIDTH-1:0];
                acc_next[DBIT] = 1'b1;
            end
            else
                rem_next = r_sh[WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= in_cmd;
        a_reg    <= a_next;
        b_reg    <= in_b;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        flip_reg <= in_flip;
        res_reg  <= in_res;
    end

    assign out_valid = valid_reg;
    assign out_cmd   = cmd_reg;
    assign out_a     = a_reg;
    assign out_b     = b_reg;
    assign out_acc   = acc_reg;
    assign out_rem   = rem_reg;
    assign out_flip  = flip_reg;
    assign out_res   = res_reg;
endmodule

@@ tb/sv/tb_wide_integer_alu.sv @@
// Testbench for the wide integer ALU: directed table then random beats, checked by a predictor.
module tb_wide_integer_alu;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned W         = 128;
    localparam int          STALL_MAX = 2000;  // idle cycles with no beat in and no result out
    localparam int          N_RANDOM  = 630;

    // codes with no operation behind them
    localparam logic [3:0] CMD_UNKNOWN_FIRST = 4'd13;
    localparam logic [3:0] CMD_UNKNOWN_LAST  = 4'd15;

    // one result beat as the block presents it
    typedef struct packed {
        logic [127:0] res;
        logic [127:0] rem;
        logic         zero;
        logic         neg;
    } alu_out_t;

    // one row of the directed table; has_exp marks rows with a typed-in answer
    typedef struct {
        logic [3:0]   op;
        logic [127:0] a;
        logic [127:0] b;
        logic [7:0]   sh;
        bit           has_exp;
        logic [127:0] exp_res;
        logic [127:0] exp_rem;
    } row_t;

    localparam logic [127:0] MIN_NEG = {1'b1, 127'd0};
    localparam logic [127:0] MAX_POS = {1'b0, {127{1'b1}}};
    localparam logic [127:0] ALL_ONE = {128{1'b1}};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [3:0]  cmd = '0;
    logic [63:0] a_high = '0, a_low = '0, b_high = '0, b_low = '0;
    logic [7:0]  shift_amount = '0;
    logic        done;
    logic [63:0] result_high, result_low, remainder_high, remainder_low;
    logic        is_zero, is_negative;

    alu_out_t pending_results[$];
    row_t     dir_rows[$];
    int       n_errors = 0;
    int       idle_cycles = 0;
    bit       drained = 1'b0;

    wide_integer_alu u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .a_high(a_high), .a_low(a_low), .b_high(b_high), .b_low(b_low),
        .shift_amount(shift_amount), .done(done),
        .result_high(result_high), .result_low(result_low),
        .remainder_high(remainder_high), .remainder_low(remainder_low),
        .is_zero(is_zero), .is_negative(is_negative)
    );

    always #10 clk = ~clk;

    // magnitude of a two's-complement operand; the most negative value maps to 2^127
    function automatic logic [127:0] magnitude(logic [127:0] x);
        return x[W-1] ? -x : x;
    endfunction

    // restoring division on magnitudes, sign fixed afterwards
    function automatic void signed_divide(input logic [127:0] a, input logic [127:0] b,
                                          output logic [127:0] quo, output logic [127:0] rem);
        logic [127:0] n, d, q;
        logic [128:0] r;
        n = magnitude(a);
        d = magnitude(b);
        q = '0;
        r = '0;
        for (int i = W - 1; i >= 0; i--) begin
            r = {r[127:0], n[i]};
            if (d != 0 && r >= {1'b0, d}) begin
                r = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        rem = r[127:0];
        quo = (a[W-1] ^ b[W-1]) ? -q : q;
    endfunction

    function automatic alu_out_t alu_predict(logic [3:0] op, logic [127:0] a,
                                             logic [127:0] b, logic [7:0] sh);
        alu_out_t o;
        logic [127:0] r, m;
        m = '0;
        case (op)
            wia_pkg::CMD_ADD:  r = a + b;
            wia_pkg::CMD_SUB:  r = a - b;
            wia_pkg::CMD_NEG:  r = -a;
            wia_pkg::CMD_MUL:  r = a * b;
            wia_pkg::CMD_DIV:  signed_divide(a, b, r, m);
            wia_pkg::CMD_AND:  r = a & b;
            wia_pkg::CMD_OR:   r = a | b;
            wia_pkg::CMD_XOR:  r = a ^ b;
            wia_pkg::CMD_NOT:  r = ~a;
            // bit 127 held, lower 127 bits shift among themselves
            wia_pkg::CMD_SHLK: r = {a[W-1], 127'(a[126:0] << sh)};
            wia_pkg::CMD_SAR:  r = $signed(a) >>> sh;
            wia_pkg::CMD_SHL:  r = a << sh;
            wia_pkg::CMD_SHR:  r = a >> sh;
            default:           r = '0;
        endcase
        o.res  = r;
        o.rem  = m;
        o.zero = (r == 0);
        o.neg  = r[W-1];
        return o;
    endfunction

    function automatic logic [127:0] rand_wide();
        logic [127:0] x;
        x = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 9))
            0: x = '0;
            1: x = ALL_ONE;
            2: x = MIN_NEG;
            3: x = MAX_POS;
            4: x = 128'($urandom_range(0, 20));          // small values
            5: x = -128'($urandom_range(1, 20));
            6: x = x >> $urandom_range(0, 127);          // assorted magnitudes
            default: ;
        endcase
        return x;
    endfunction

    // append one row to the directed table
    task automatic add_row(input row_t r_in);
        dir_rows.insert(dir_rows.size(), r_in);
    endtask

    // issue one beat: random gap, then hold start until taken (busy may stay low)
    task automatic send_beat(logic [3:0] op, logic [127:0] a, logic [127:0] b, logic [7:0] sh);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        cmd          <= op;
        {a_high, a_low} <= a;
        {b_high, b_low} <= b;
        shift_amount <= sh;
        @(posedge clk);
        while (busy) @(posedge clk);
        pending_results.insert(pending_results.size(), alu_predict(op, a, b, sh));
    endtask

    // result monitor: done marks a beat valid for exactly one cycle
    always @(posedge clk)
    begin
        alu_out_t want;
        if (rst_n && done) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected");
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if ({result_high, result_low} !== want.res) begin
                    $error("result: expected %h actual %h", want.res, {result_high, result_low});
                    n_errors++;
                end
                if ({remainder_high, remainder_low} !== want.rem) begin
                    $error("remainder: expected %h actual %h", want.rem,
                           {remainder_high, remainder_low});
                    n_errors++;
                end
                if (is_zero !== want.zero) begin
                    $error("is_zero: expected %b actual %b", want.zero, is_zero);
                    n_errors++;
                end
                if (is_negative !== want.neg) begin
                    $error("is_negative: expected %b actual %b", want.neg, is_negative);
                    n_errors++;
                end
            end
        end
    end

    // watchdog: counts cycles with neither a beat in nor a result out
    always @(posedge clk)
    begin
        if ((start && !busy) || done || drained)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        row_t         rw;
        alu_out_t     chk;
        logic [3:0]   op;
        logic [127:0] a, b;
        logic [7:0]   sh;
        int           wait_n;

        // directed rows: extremes, every command, divide corner cases, long shifts
        add_row('{wia_pkg::CMD_ADD, MAX_POS, 128'd1, 8'd0, 1, MIN_NEG, '0});
        add_row('{wia_pkg::CMD_ADD, ALL_ONE, ALL_ONE, 8'd0, 0, '0, '0});
        add_row('{wia_pkg::CMD_SUB, '0, 128'd1, 8'd0, 1, ALL_ONE, '0});
        add_row('{wia_pkg::CMD_NEG, MIN_NEG, '0, 8'd0, 1, MIN_NEG, '0});
        add_row('{wia_pkg::CMD_NEG, '0, '0, 8'd0, 1, '0, '0});
        add_row('{wia_pkg::CMD_MUL, ALL_ONE, ALL_ONE, 8'd0, 1, 128'd1, '0});
        add_row('{wia_pkg::CMD_MUL, MIN_NEG, 128'd2, 8'd0, 1, '0, '0});
        add_row('{wia_pkg::CMD_DIV, 128'd7, '0, 8'd0, 1, '0, 128'd7});
        add_row('{wia_pkg::CMD_DIV, MIN_NEG, '0, 8'd0, 1, '0, MIN_NEG});
        add_row('{wia_pkg::CMD_DIV, MIN_NEG, ALL_ONE, 8'd0, 1, MIN_NEG, '0});
        add_row('{wia_pkg::CMD_DIV, -128'd7, 128'd2, 8'd0, 1, -128'd3, 128'd1});
        add_row('{wia_pkg::CMD_DIV, 128'd7, -128'd2, 8'd0, 1, -128'd3, 128'd1});
        add_row('{wia_pkg::CMD_DIV, MAX_POS, 128'd3, 8'd0, 0, '0, '0});
        add_row('{wia_pkg::CMD_AND, ALL_ONE, MIN_NEG, 8'd0, 1, MIN_NEG, '0});
        add_row('{wia_pkg::CMD_OR, MIN_NEG, 128'd1, 8'd0, 1, MIN_NEG | 128'd1, '0});
        add_row('{wia_pkg::CMD_XOR, ALL_ONE, ALL_ONE, 8'd0, 1, '0, '0});
        add_row('{wia_pkg::CMD_NOT, '0, '0, 8'd0, 1, ALL_ONE, '0});
        add_row('{wia_pkg::CMD_SHLK, ALL_ONE, '0, 8'd0, 1, ALL_ONE, '0});
        add_row('{wia_pkg::CMD_SHLK, ALL_ONE, '0, 8'd255, 1, MIN_NEG, '0});
        add_row('{wia_pkg::CMD_SAR, MIN_NEG, '0, 8'd128, 1, ALL_ONE, '0});
        add_row('{wia_pkg::CMD_SAR, MAX_POS, '0, 8'd126, 1, 128'd1, '0});
        add_row('{wia_pkg::CMD_SHL, ALL_ONE, '0, 8'd128, 1, '0, '0});
        add_row('{wia_pkg::CMD_SHR, ALL_ONE, '0, 8'd127, 1, 128'd1, '0});
        add_row('{CMD_UNKNOWN_FIRST, ALL_ONE, ALL_ONE, 8'd5, 1, '0, '0});
        add_row('{CMD_UNKNOWN_LAST, ALL_ONE, ALL_ONE, 8'd255, 1, '0, '0});

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            rw = dir_rows[i];
            // typed-in answers cross-check the predictor itself
            if (rw.has_exp) begin
                chk = alu_predict(rw.op, rw.a, rw.b, rw.sh);
                if (chk.res !== rw.exp_res || chk.rem !== rw.exp_rem) begin
                    $error("table row %0d: expected %h/%h predicted %h/%h", i,
                           rw.exp_res, rw.exp_rem, chk.res, chk.rem);
                    n_errors++;
                end
            end
            send_beat(rw.op, rw.a, rw.b, rw.sh);
        end

        for (int k = 0; k < N_RANDOM; k++)
        begin
            op = 4'($urandom_range(0, 15));
            if (op > wia_pkg::CMD_SHR && $urandom_range(0, 3) != 0)
                op = 4'($urandom_range(0, wia_pkg::CMD_SHR));   // keep unknown codes rare
            a  = rand_wide();
            b  = rand_wide();
            sh = $urandom_range(0, 3) == 0 ? 8'($urandom_range(120, 255))
                                           : 8'($urandom_range(0, 127));
            send_beat(op, a, b, sh);
        end
        start <= 1'b0;

        // drain: watchdog still runs until the queue empties
        while (pending_results.size() != 0) @(posedge clk);
        drained = 1'b1;
        wait_n = 0;
        while (wait_n < W + 10)
        begin
            @(posedge clk);
            wait_n++;
        end

        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/wia_pkg.sv
rtl/wia_cell.sv
rtl/wide_integer_alu.sv
tb/sv/tb_wide_integer_alu.sv
